FILE: hw/rtl/dht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types, codes and sizes of the double hashing table.
// ----------------------------------------------------------------------------
package dht_pkg;

    localparam int KEY_W            = 31;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int SLOT_W           = 4;
    localparam int TABLE_SIZE_DEF   = 13;
    localparam int STEP_MODULUS_DEF = 11;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_out_word;

endpackage

`default_nettype wire

FILE: hw/rtl/dht_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_front
// Takes a command word, works out the home slot and the probe step by
// reciprocal multiplication, and hands the job to the queue.
// ----------------------------------------------------------------------------
module dht_front import dht_pkg::*; #(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int STEP_MODULUS = STEP_MODULUS_DEF,
    localparam int HW          = $clog2(TABLE_SIZE),
    localparam int JOB_W       = OP_W + KEY_W + 2 * HW
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_in_word         i_word,
    output logic                  o_busy,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job,
    input  wire logic             i_full
);

    // q = (x * m) >> s is exact for every x below 2**n with s = n + clog2(d)
    localparam int SWL = $clog2(STEP_MODULUS);
    localparam int VW  = $clog2(STEP_MODULUS + 1);
    localparam int SH  = KEY_W + HW;
    localparam int SS  = KEY_W + SWL;
    localparam int SV  = VW + HW;
    localparam int PH  = KEY_W + SH;
    localparam int PS  = KEY_W + SS;
    localparam int PV  = VW + SV;

    localparam longint M_H_L = ((longint'(1) << SH) + longint'(TABLE_SIZE) - 1) /
                               longint'(TABLE_SIZE);
    localparam longint M_S_L = ((longint'(1) << SS) + longint'(STEP_MODULUS) - 1) /
                               longint'(STEP_MODULUS);
    localparam longint M_V_L = ((longint'(1) << SV) + longint'(TABLE_SIZE) - 1) /
                               longint'(TABLE_SIZE);

    localparam logic [KEY_W+1:0] M_H = (KEY_W+2)'(M_H_L);
    localparam logic [KEY_W+1:0] M_S = (KEY_W+2)'(M_S_L);
    localparam logic [VW+1:0]    M_V = (VW+2)'(M_V_L);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_SUB  = 6'b000100,
        F_VMUL = 6'b001000,
        F_VSUB = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [OP_W-1:0]  r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_qh, n_qh;
    logic [KEY_W-1:0] r_qs, n_qs;
    logic [VW-1:0]    r_v, n_v;
    logic [VW-1:0]    r_qv, n_qv;
    logic [HW-1:0]    r_home, n_home;
    logic [HW-1:0]    r_step, n_step;

    logic [PH-1:0]    prod_h;
    logic [PS-1:0]    prod_s;
    logic [PV-1:0]    prod_v;
    logic [KEY_W-1:0] rem_h;
    logic [KEY_W-1:0] rem_s;
    logic [VW-1:0]    rem_v;

    assign prod_h = PH'(r_key) * PH'(M_H);
    assign prod_s = PS'(r_key) * PS'(M_S);
    assign prod_v = PV'(r_v) * PV'(M_V);
    assign rem_h  = r_key - r_qh * KEY_W'(TABLE_SIZE);
    assign rem_s  = r_key - r_qs * KEY_W'(STEP_MODULUS);
    assign rem_v  = r_v - r_qv * VW'(TABLE_SIZE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_qh    = r_qh;
        n_qs    = r_qs;
        n_v     = r_v;
        n_qv    = r_qv;
        n_home  = r_home;
        n_step  = r_step;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_op    = i_word.op;
                    n_key   = i_word.key;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_qh    = prod_h[PH-1:SH];
                n_qs    = prod_s[PS-1:SS];
                n_state = F_SUB;
            end
            F_SUB: begin
                n_home  = rem_h[HW-1:0];
                n_v     = VW'(rem_s) + VW'(1);
                n_state = F_VMUL;
            end
            F_VMUL: begin
                n_qv    = prod_v[PV-1:SV];
                n_state = F_VSUB;
            end
            F_VSUB: begin
                n_step  = HW'(rem_v);
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_qh   <= n_qh;
        r_qs   <= n_qs;
        r_v    <= n_v;
        r_qv   <= n_qv;
        r_home <= n_home;
        r_step <= n_step;
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_job  = {r_op, r_key, r_home, r_step};

endmodule

`default_nettype wire

FILE: hw/rtl/dht_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_queue
// Small first-in first-out buffer of hashed jobs between front and back.
// ----------------------------------------------------------------------------
module dht_queue import dht_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [AW:0]      r_wr_ptr, n_wr_ptr;
    logic [AW:0]      r_rd_ptr, n_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_data  = r_data[r_rd_ptr[AW-1:0]];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push && !o_full) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_data[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dht_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_back
// Walks the probe sequence of one job through the slot memory, one slot a
// cycle, applies the insert or delete and registers the result word.
// ----------------------------------------------------------------------------
module dht_back import dht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int HW        = $clog2(TABLE_SIZE),
    localparam int JOB_W     = OP_W + KEY_W + 2 * HW
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [JOB_W-1:0] i_job,
    input  wire logic             i_empty,
    output logic                  o_pop,
    output logic                  o_result_valid,
    output t_out_word             o_result
);

    localparam int CNW = $clog2(TABLE_SIZE + 1);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_PROBE = 3'b100
    } t_bstate;

    function automatic logic [HW-1:0] f_adv(input logic [HW-1:0] p, input logic [HW-1:0] s);
        logic [HW:0] n;
        n = {1'b0, p} + {1'b0, s};
        if (n >= (HW+1)'(TABLE_SIZE)) begin
            n = n - (HW+1)'(TABLE_SIZE);
        end
        return n[HW-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot(input logic [HW-1:0] p);
        logic [SLOT_W+HW-1:0] w;
        w = {{SLOT_W{1'b0}}, p};
        return w[SLOT_W-1:0];
    endfunction

    // slot memory: valid flag on top of the key
    logic [KEY_W:0]   r_slots [TABLE_SIZE];
    logic [KEY_W:0]   r_rd;

    t_bstate          r_state, n_state;
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [HW-1:0]    r_step;
    logic [HW-1:0]    r_pos, n_pos;
    logic [CNW-1:0]   r_iss, n_iss;
    logic             r_cmp_vld, n_cmp_vld;
    logic [HW-1:0]    r_cmp_pos, n_cmp_pos;
    logic [CNW-1:0]   r_cnt, n_cnt;
    logic             r_res_vld, n_res_vld;
    t_out_word        r_res, n_res;

    logic [OP_W-1:0]  j_op;
    logic [KEY_W-1:0] j_key;
    logic [HW-1:0]    j_home;
    logic [HW-1:0]    j_step;

    logic             rd_en;
    logic             wr_en;
    logic [HW-1:0]    wr_addr;
    logic [KEY_W:0]   wr_data;
    logic             hit;

    assign j_step = i_job[HW-1:0];
    assign j_home = i_job[2*HW-1:HW];
    assign j_key  = i_job[2*HW+KEY_W-1:2*HW];
    assign j_op   = i_job[JOB_W-1:JOB_W-OP_W];

    assign hit = r_cmp_vld && ((r_op == OP_INSERT) ? !r_rd[KEY_W] :
                 (r_rd[KEY_W] && (r_rd[KEY_W-1:0] == r_key)));

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_iss     = r_iss;
        n_cmp_vld = r_cmp_vld;
        n_cmp_pos = r_cmp_pos;
        n_cnt     = r_cnt;
        n_res_vld = 1'b0;
        n_res     = r_res;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = '0;
        unique case (r_state)
            B_CLEAR: begin
                wr_en = 1'b1;
                if (r_pos == HW'(TABLE_SIZE - 1)) begin
                    n_pos   = '0;
                    n_state = B_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_pos     = j_home;
                    n_iss     = '0;
                    n_cmp_vld = 1'b0;
                    if (j_op == OP_INSERT && r_cnt == CNW'(TABLE_SIZE)) begin
                        n_res_vld = 1'b1;
                        n_res     = '{status: ST_FULL, slot: '0};
                    end else if (j_op == OP_INSERT || j_op == OP_SEARCH ||
                                 j_op == OP_DELETE) begin
                        n_state = B_PROBE;
                    end else begin
                        n_res_vld = 1'b1;
                        n_res     = '{status: ST_MISSING, slot: '0};
                    end
                end
            end
            B_PROBE: begin
                if (r_iss < CNW'(TABLE_SIZE)) begin
                    rd_en     = 1'b1;
                    n_pos     = f_adv(r_pos, r_step);
                    n_iss     = r_iss + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_pos = r_pos;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (hit) begin
                    wr_addr   = r_cmp_pos;
                    n_res_vld = 1'b1;
                    n_res     = '{status: ST_DONE, slot: f_slot(r_cmp_pos)};
                    n_cmp_vld = 1'b0;
                    n_state   = B_IDLE;
                    if (r_op == OP_INSERT) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, r_key};
                        n_cnt   = r_cnt + 1'b1;
                    end else if (r_op == OP_DELETE) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b0, r_key};
                        n_cnt   = r_cnt - 1'b1;
                    end
                end else if (r_cmp_vld && r_iss == CNW'(TABLE_SIZE)) begin
                    n_res_vld = 1'b1;
                    n_res     = '{status: (r_op == OP_INSERT) ? ST_FULL : ST_MISSING,
                                  slot: '0};
                    n_cmp_vld = 1'b0;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_pos     <= '0;
            r_iss     <= '0;
            r_cmp_vld <= 1'b0;
            r_cnt     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_iss     <= n_iss;
            r_cmp_vld <= n_cmp_vld;
            r_cnt     <= n_cnt;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_pos <= n_cmp_pos;
        r_res     <= n_res;
        if (o_pop) begin
            r_op   <= j_op;
            r_key  <= j_key;
            r_step <= j_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slots[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_slots[r_pos];
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

endmodule

`default_nettype wire

FILE: hw/rtl/double_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressed key table with double hashing: insert, search and delete.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. The front
// works out key mod TABLE_SIZE and (1 + key mod STEP_MODULUS) mod TABLE_SIZE
// by reciprocal multiplication, each product followed by a subtract step;
// busy stays high after a word is taken until its job is pushed, which
// waits while the two-entry queue is full. The back pops a job and probes one
// slot a cycle, the compare in the cycle after the read, and stops early
// when it finds the key or, for an insert, an empty slot; an insert into a
// full table or an unused op is answered without a probe. The back pops the
// next job only once it is through with the last. Each word gives one
// result word, shown for one cycle with o_result_valid; the receiver cannot
// stall it. After reset the back clears every slot of the slot memory before
// it starts on the first job.
module double_hash_table import dht_pkg::*; #(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int STEP_MODULUS = STEP_MODULUS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_word  i_in,
    output logic           o_result_valid,
    output t_out_word      o_result
);

    localparam int HW    = $clog2(TABLE_SIZE);
    localparam int JOB_W = OP_W + KEY_W + 2 * HW;

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;

    dht_front #(
        .TABLE_SIZE   (TABLE_SIZE),
        .STEP_MODULUS (STEP_MODULUS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_word  (i_in),
        .o_busy  (busy),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    dht_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    dht_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job_out),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/dht_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks on the double hashing table, bound to the top level.
// ----------------------------------------------------------------------------
module dht_checker import dht_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      o_result_valid,
    input wire t_out_word o_result
);

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result word right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status != ST_DONE |-> o_result.slot == '0)
        else $error("nonzero slot on a failed command");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.status == ST_DONE |->
            (TABLE_SIZE > 16) || (o_result.slot < TABLE_SIZE))
        else $error("slot beyond table");

endmodule

bind double_hash_table dht_checker #(
    .TABLE_SIZE (TABLE_SIZE)
) u_dht_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

FILE: tb/sv/dht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dht_checker
// Watches the command and result channels of the double hashing table. It
// keeps its own copy of the slot contents, works out the status and slot of
// every accepted command word, and compares each result word with the oldest
// expected one.
// ----------------------------------------------------------------------------
module tb_dht_checker import dht_pkg::*; #(
    parameter int TABLE_SIZE   = TABLE_SIZE_DEF,
    parameter int STEP_MODULUS = STEP_MODULUS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire logic      i_busy,
    input  wire t_in_word  i_in,
    input  wire logic      i_result_valid,
    input  wire t_out_word i_result,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_done_seen,
    output int             o_missing_seen,
    output int             o_full_seen
);

    logic [KEY_W-1:0] stored_key [TABLE_SIZE];
    bit               slot_used  [TABLE_SIZE];
    int               used_count;
    t_out_word        expected_q [$];
    int               fail_count;

    function automatic t_out_word apply_command(t_in_word w);
        t_out_word r;
        longint    k;
        int        pos;
        int        hop;
        int        i;
        bit        hit;
        k        = longint'(w.key);
        pos      = int'(k % TABLE_SIZE);
        hop      = int'((1 + k % STEP_MODULUS) % TABLE_SIZE);
        hit      = 1'b0;
        r.status = ST_MISSING;
        r.slot   = '0;
        case (w.op)
            OP_INSERT: begin
                r.status = ST_FULL;
                if (used_count < TABLE_SIZE) begin
                    for (i = 0; i < TABLE_SIZE && !hit; i++) begin
                        if (!slot_used[pos]) begin
                            slot_used[pos]  = 1'b1;
                            stored_key[pos] = w.key;
                            used_count++;
                            r.status = ST_DONE;
                            r.slot   = SLOT_W'(pos);
                            hit      = 1'b1;
                        end else begin
                            pos = (pos + hop) % TABLE_SIZE;
                        end
                    end
                end
            end
            OP_SEARCH, OP_DELETE: begin
                for (i = 0; i < TABLE_SIZE && !hit; i++) begin
                    if (slot_used[pos] && stored_key[pos] == w.key) begin
                        hit      = 1'b1;
                        r.status = ST_DONE;
                        r.slot   = SLOT_W'(pos);
                        if (w.op == OP_DELETE) begin
                            slot_used[pos] = 1'b0;
                            if (used_count > 0) used_count--;
                        end
                    end else begin
                        pos = (pos + hop) % TABLE_SIZE;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            foreach (slot_used[j]) slot_used[j] = 1'b0;
            used_count = 0;
            expected_q.delete();
            fail_count = 0;
            o_done_seen    <= 0;
            o_missing_seen <= 0;
            o_full_seen    <= 0;
        end else begin
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: status %0d slot %0d",
                                 i_result.status, i_result.slot);
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.status !== want.status || i_result.slot !== want.slot) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                     want.status, want.slot, i_result.status, i_result.slot);
                    end
                    case (want.status)
                        ST_DONE:    o_done_seen    <= o_done_seen + 1;
                        ST_MISSING: o_missing_seen <= o_missing_seen + 1;
                        default:    o_full_seen    <= o_full_seen + 1;
                    endcase
                end
            end
            if (i_start && !i_busy)
                expected_q.push_back(apply_command(i_in));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
    end

endmodule

FILE: tb/sv/tb_double_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_hash_table
// Drives insert, search, delete and unused commands into the double hashing
// table: a directed opening with extreme keys, duplicates and a full table,
// then random blocks that lean toward filling or draining the table, with
// random gaps between command words. The checker scores every result word.
// ----------------------------------------------------------------------------
module tb_double_hash_table;
    import dht_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};
    localparam int               POOL_SIZE  = 24;
    localparam int               RAND_WORDS = 1450;
    localparam int               BLOCK_LEN  = 50;
    localparam int               IDLE_LIMIT = 2000;
    localparam int               TAIL_WAIT  = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_word  i_in;
    logic      o_result_valid;
    t_out_word o_result;

    int fail_count;
    int pending;
    int done_seen;
    int missing_seen;
    int full_seen;
    int words_sent;
    int idle_cycles;
    int drain_pauses;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    double_hash_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_in           (i_in),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    tb_dht_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_in           (i_in),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_done_seen    (done_seen),
        .o_missing_seen (missing_seen),
        .o_full_seen    (full_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // called at a rising edge; returns at the edge that takes the word, or after the gap with start dropped
    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input int gap);
        start   <= 1'b1;
        i_in.op  <= op;
        i_in.key <= key;
        do @(posedge i_clk); while (busy);
        words_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_table_jobs();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        drain_pauses++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input bit from_pool_often);
        int r;
        r = $urandom_range(0, 99);
        if (r < (from_pool_often ? 65 : 35)) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 80) return KEY_W'($urandom_range(0, 60));
        if (r < 92) return KEY_W'($urandom);
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return KEY_MAX;
            default: return KEY_MAX - KEY_W'($urandom_range(0, 40));
        endcase
    endfunction

    initial begin
        int               blk;
        int               n;
        int               bias;
        int               r;
        bit               quiet;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_in         <= '0;
        words_sent   = 0;
        drain_pauses = 0;
        foreach (key_pool[j]) key_pool[j] = KEY_W'(j * 13 + j % 3);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        send_word(OP_INSERT, '0, 0);
        send_word(OP_INSERT, KEY_MAX, $urandom_range(0, 9));
        send_word(OP_SEARCH, KEY_MAX, 0);
        send_word(OP_SEARCH, KEY_W'(5), $urandom_range(0, 9));
        send_word(OP_DELETE, '0, 0);
        send_word(OP_DELETE, '0, 0);
        send_word(OP_UNUSED, KEY_MAX, $urandom_range(0, 9));
        repeat (12) send_word(OP_INSERT, KEY_W'(26), $urandom_range(0, 2));
        send_word(OP_INSERT, KEY_W'(1), 0);
        send_word(OP_SEARCH, KEY_W'(26), 0);
        send_word(OP_DELETE, KEY_W'(26), $urandom_range(0, 9));
        send_word(OP_INSERT, KEY_W'(39), 0);
        send_word(OP_DELETE, KEY_MAX, 0);
        send_word(OP_SEARCH, KEY_MAX, 0);
        drain_table_jobs();

        // random blocks leaning toward fill, mix or drain
        for (blk = 0; blk * BLOCK_LEN < RAND_WORDS; blk++) begin
            bias  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < BLOCK_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_UNUSED;
                else if (r < (bias == 0 ? 70 : bias == 1 ? 45 : 25))
                    op = OP_INSERT;
                else if (r < (bias == 2 ? 45 : 80))
                    op = OP_SEARCH;
                else
                    op = OP_DELETE;
                key = pick_key(op != OP_INSERT);
                if (op == OP_INSERT && $urandom_range(0, 1) == 1)
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = key;
                send_word(op, key, quiet ? 0 : $urandom_range(0, 9));
            end
            if (blk % 8 == 7) drain_table_jobs();
        end

        drain_table_jobs();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d command words: %0d done, %0d not found, %0d refused as full",
                 words_sent, done_seen, missing_seen, full_seen);
        $display("sender held off %0d times until all results had come", drain_pauses);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/dht_pkg.sv
hw/rtl/dht_front.sv
hw/rtl/dht_queue.sv
hw/rtl/dht_back.sv
hw/rtl/double_hash_table.sv
hw/rtl/dht_checker.sv
tb/sv/dht_checker.sv
tb/sv/tb_double_hash_table.sv
